[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ETK_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ETK_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/etk_pkg.sv]
package etk_pkg;

   // Store geometry
   localparam int ENTRIES    = 1024;
   localparam int DIMENSIONS = 64;
   localparam int TOP_K      = 8;
   localparam int SLOTS      = 4;
   localparam int LANES      = 8;
   localparam int WORDS      = (DIMENSIONS + LANES - 1) / LANES;

   // Field widths
   localparam int OP_W      = 3;
   localparam int SLOT_W    = 2;
   localparam int ARG_W     = 10;
   localparam int BYTE_W    = 8;
   localparam int ST_W      = 3;
   localparam int IDX_W     = 10;
   localparam int SCORE_O_W = 22;
   localparam int RANK_W    = 3;
   localparam int MC_W      = 4;
   localparam int EC_W      = 11;

   // Derived widths
   localparam int WORD_W    = $clog2(WORDS);
   localparam int WORD_BITS = LANES * BYTE_W;
   localparam int ENT_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int VADDR_W   = SLOT_W + ENT_W;
   localparam int MADDR_W   = VADDR_W + WORD_W;
   localparam int PROD_W    = 2 * BYTE_W;
   localparam int SUM_W     = PROD_W + $clog2(LANES);
   localparam int SCORE_W   = $clog2(DIMENSIONS * 65025 + 1);
   localparam int K_W       = $clog2(TOP_K);
   localparam int KN_W      = $clog2(TOP_K + 1);

   // Bus widths
   localparam int REQ_FIELDS_W = OP_W + SLOT_W + ARG_W + WORD_BITS;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ST_W + IDX_W + SCORE_O_W + RANK_W + MC_W + EC_W;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Opcodes
   localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // Status codes
   localparam logic [ST_W-1:0] STS_OK     = 3'd0;
   localparam logic [ST_W-1:0] STS_BAD    = 3'd1;
   localparam logic [ST_W-1:0] STS_NOINIT = 3'd2;
   localparam logic [ST_W-1:0] STS_FULL   = 3'd3;
   localparam logic [ST_W-1:0] STS_NOENT  = 3'd4;

   // Tags that travel with one vector word through the lanes
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             hit;
      logic [ENT_W-1:0] index;
   } dot_tag_type;

   // Finished entry score offered to the ranking list
   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
      logic [ENT_W-1:0]   index;
   } cand_type;

endpackage

[rtl/core/embedding_topk_index_top.sv]
// Channel   Direction  Transaction
// req_*     in         one command word: opcode, slot, argument, eight vector bytes
// rsp_*     out        one result: status, index, score, rank, counts
//
// After reset a clearing pass over all SLOTS*ENTRIES valid bits runs with
// req_tready low; a non-final vector word is staged while the state stays
// idle. Delete reads and clears one valid bit, init and clear sweep the
// slot's ENTRIES valid bits, and insert scans for the lowest free entry.
// Query reads ENTRIES*WORDS words, one vector word per cycle through the
// memory read port, then sends its results; a result waits in the output
// register while rsp_tready is low.
module embedding_topk_index_top import etk_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // opcode, slot, argument, lane_0 .. lane_7, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status, shard_index, score, rank, match_count, entry_count, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int DRAIN_CYCLES = 6;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES + 1);

   typedef enum logic [3:0] {
      S_RCLR, S_IDLE, S_CHECK, S_SWEEP, S_INS_RD, S_INS_CK, S_INS_WR,
      S_DEL_RD, S_DEL_CK, S_QRY, S_DRAIN, S_RESULT
   } state_type;

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [ARG_W-1:0]     arg_ff, arg_in;
   logic [WORD_W-1:0]    wctr_ff, wctr_in;
   logic [WORD_BITS-1:0] staging_ff [WORDS];
   logic                 stg_we;
   logic                 ready_ff [SLOTS];
   logic                 ready_in [SLOTS];
   logic [CNT_W-1:0]     count_ff [SLOTS];
   logic [CNT_W-1:0]     count_in [SLOTS];
   logic [VADDR_W-1:0]   ctr_ff, ctr_in;
   logic [WORD_W-1:0]    w_ff, w_in;
   logic [DRAIN_W-1:0]   drain_ff, drain_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic                 qmode_ff, qmode_in;
   logic [ST_W-1:0]      res_st_ff, res_st_in;
   logic [CNT_W-1:0]     res_cnt_ff, res_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Memories and query pipeline
   logic [WORD_BITS-1:0] vec_mem [SLOTS*ENTRIES*WORDS];
   logic                 valid_mem [SLOTS*ENTRIES];
   logic [WORD_BITS-1:0] vec_q_ff;
   logic                 vld_q_ff;
   logic [WORD_BITS-1:0] stg_q_ff, stg_q_in;
   dot_tag_type          tag0_ff, tag0_in;
   dot_tag_type          dot_tag;
   logic                 vec_we;
   logic [MADDR_W-1:0]   vec_addr;
   logic                 vld_we, vld_wdata;
   logic [VADDR_W-1:0]   vld_waddr, vld_raddr;

   cand_type             cand;
   logic                 topk_clear;
   logic [KN_W-1:0]      want;
   logic [SCORE_W-1:0]   topk_score [TOP_K];
   logic [ENT_W-1:0]     topk_index [TOP_K];
   logic [KN_W-1:0]      topk_n;

   logic                 accept, out_free, slot_ok, is_vec, cur_ready;
   logic [OP_W-1:0]      req_op;
   logic [SLOT_W-1:0]    req_slot;
   logic [ARG_W-1:0]     req_arg;
   logic [WORD_BITS-1:0] req_lanes;
   logic [CNT_W-1:0]     cur_cnt;
   logic [ENT_W-1:0]     ent;
   logic [ST_W-1:0]      o_status;
   logic [IDX_W-1:0]     o_index;
   logic [SCORE_O_W-1:0] o_score;
   logic [RANK_W-1:0]    o_rank;
   logic [MC_W-1:0]      o_mc;
   logic [EC_W-1:0]      o_ec;

   // Unpack the request
   assign req_op    = req_tdata[OP_W-1:0];
   assign req_slot  = req_tdata[OP_W +: SLOT_W];
   assign req_arg   = req_tdata[OP_W+SLOT_W +: ARG_W];
   assign req_lanes = req_tdata[OP_W+SLOT_W+ARG_W +: WORD_BITS];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign is_vec     = (req_op == OP_INSERT) || (req_op == OP_QUERY);
   assign stg_we     = accept & is_vec;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign slot_ok    = (32'(slot_ff) < SLOTS);
   assign cur_ready  = ready_ff[slot_ff];
   assign cur_cnt    = count_ff[slot_ff];
   assign ent        = ctr_ff[ENT_W-1:0];
   assign want       = (32'(arg_ff) > TOP_K) ? KN_W'(TOP_K) : KN_W'(arg_ff);
   assign vec_addr   = {slot_ff, ent, w_ff};
   assign stg_q_in   = staging_ff[w_ff];

   // Control sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      arg_in       = arg_ff;
      wctr_in      = wctr_ff;
      ready_in     = ready_ff;
      count_in     = count_ff;
      ctr_in       = ctr_ff;
      w_in         = w_ff;
      drain_in     = drain_ff;
      k_in         = k_ff;
      qmode_in     = qmode_ff;
      res_st_in    = res_st_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      vec_we       = 1'b0;
      vld_we       = 1'b0;
      vld_wdata    = 1'b0;
      vld_waddr    = {slot_ff, ent};
      vld_raddr    = {slot_ff, ent};
      tag0_in      = '0;
      topk_clear   = 1'b0;
      o_status     = res_st_ff;
      o_index      = '0;
      o_score      = '0;
      o_rank       = '0;
      o_mc         = '0;
      o_ec         = EC_W'(res_cnt_ff);

      case (state_ff)
         // Zero every valid bit after reset
         S_RCLR: begin
            vld_we    = 1'b1;
            vld_waddr = ctr_ff;
            if (ctr_ff == VADDR_W'(SLOTS*ENTRIES-1)) begin
               ctr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ctr_in = ctr_ff + 1'b1;
            end
         end

         // Take a transaction; stage vector words until the final one
         S_IDLE: begin
            if (accept) begin
               if (is_vec) begin
                  if (req_tlast) begin
                     wctr_in = '0;
                  end else if (wctr_ff == WORD_W'(WORDS-1)) begin
                     wctr_in = '0;
                  end else begin
                     wctr_in = wctr_ff + 1'b1;
                  end
               end
               if ((!is_vec || req_tlast) && req_op <= OP_CLEAR) begin
                  op_in    = req_op;
                  slot_in  = req_slot;
                  arg_in   = req_arg;
                  state_in = S_CHECK;
               end
            end
         end

         // Check the status codes in order and pick the operation
         S_CHECK: begin
            ctr_in   = '0;
            w_in     = '0;
            qmode_in = 1'b0;
            state_in = S_RESULT;
            if (!slot_ok) begin
               res_st_in  = STS_BAD;
               res_cnt_in = '0;
            end else begin
               res_cnt_in = cur_cnt;
               case (op_ff)
                  OP_INIT: begin
                     ready_in[slot_ff] = 1'b1;
                     count_in[slot_ff] = '0;
                     res_st_in         = STS_OK;
                     res_cnt_in        = '0;
                     state_in          = S_SWEEP;
                  end
                  OP_DELETE: begin
                     if (32'(arg_ff) >= ENTRIES) begin
                        res_st_in = STS_BAD;
                     end else if (!cur_ready) begin
                        res_st_in = STS_NOINIT;
                     end else begin
                        state_in = S_DEL_RD;
                     end
                  end
                  default: begin
                     if (!cur_ready) begin
                        res_st_in = STS_NOINIT;
                     end else if (op_ff == OP_CLEAR) begin
                        count_in[slot_ff] = '0;
                        res_st_in         = STS_OK;
                        res_cnt_in        = '0;
                        state_in          = S_SWEEP;
                     end else if (op_ff == OP_INSERT) begin
                        if (cur_cnt >= CNT_W'(ENTRIES)) begin
                           res_st_in = STS_FULL;
                        end else begin
                           state_in = S_INS_RD;
                        end
                     end else begin
                        res_st_in = STS_OK;
                        if (want != '0) begin
                           topk_clear = 1'b1;
                           state_in   = S_QRY;
                        end
                     end
                  end
               endcase
            end
         end

         // Clear the valid bits of one slot
         S_SWEEP: begin
            vld_we = 1'b1;
            if (ctr_ff == VADDR_W'(ENTRIES-1)) begin
               state_in = S_RESULT;
            end else begin
               ctr_in = ctr_ff + 1'b1;
            end
         end

         // Scan for the lowest free entry
         S_INS_RD: begin
            state_in = S_INS_CK;
         end

         S_INS_CK: begin
            if (!vld_q_ff) begin
               state_in = S_INS_WR;
            end else if (ctr_ff == VADDR_W'(ENTRIES-1)) begin
               res_st_in = STS_FULL;
               state_in  = S_RESULT;
            end else begin
               ctr_in   = ctr_ff + 1'b1;
               state_in = S_INS_RD;
            end
         end

         // Copy the staged words into the free entry
         S_INS_WR: begin
            vec_we = 1'b1;
            if (w_ff == WORD_W'(WORDS-1)) begin
               vld_we            = 1'b1;
               vld_wdata         = 1'b1;
               count_in[slot_ff] = cur_cnt + 1'b1;
               res_st_in         = STS_OK;
               res_cnt_in        = cur_cnt + 1'b1;
               state_in          = S_RESULT;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end

         // Tombstone one entry
         S_DEL_RD: begin
            vld_raddr = {slot_ff, arg_ff[ENT_W-1:0]};
            state_in  = S_DEL_CK;
         end

         S_DEL_CK: begin
            vld_waddr = {slot_ff, arg_ff[ENT_W-1:0]};
            state_in  = S_RESULT;
            if (!vld_q_ff) begin
               res_st_in = STS_NOENT;
            end else begin
               vld_we    = 1'b1;
               res_st_in = STS_OK;
               if (cur_cnt != '0) begin
                  count_in[slot_ff] = cur_cnt - 1'b1;
                  res_cnt_in        = cur_cnt - 1'b1;
               end
            end
         end

         // Issue one vector word per cycle to the lanes
         S_QRY: begin
            tag0_in.valid = 1'b1;
            tag0_in.first = (w_ff == '0);
            tag0_in.last  = (w_ff == WORD_W'(WORDS-1));
            tag0_in.index = ent;
            if (w_ff == WORD_W'(WORDS-1)) begin
               w_in = '0;
               if (ctr_ff == VADDR_W'(ENTRIES-1)) begin
                  drain_in = '0;
                  state_in = S_DRAIN;
               end else begin
                  ctr_in = ctr_ff + 1'b1;
               end
            end else begin
               w_in = w_ff + 1'b1;
            end
         end

         // Let the last scores reach the ranking list
         S_DRAIN: begin
            if (drain_ff == DRAIN_W'(DRAIN_CYCLES)) begin
               qmode_in = 1'b1;
               k_in     = '0;
               state_in = S_RESULT;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end

         // Load results into the output register
         S_RESULT: begin
            if (qmode_ff && topk_n != '0) begin
               o_status = STS_OK;
               o_index  = IDX_W'(topk_index[k_ff]);
               o_score  = topk_score[k_ff][SCORE_O_W-1:0];
               o_rank   = RANK_W'(k_ff);
               o_mc     = MC_W'(topk_n);
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_W-RSP_FIELDS_W)'(0), o_ec, o_mc, o_rank, o_score,
                               o_index, o_status};
               if (qmode_ff && topk_n != '0 && KN_W'(k_ff) != topk_n - 1'b1) begin
                  rsp_last_in = 1'b0;
                  k_in        = k_ff + 1'b1;
               end else begin
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RCLR;
         wctr_ff      <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tag0_ff      <= '0;
         for (int s = 0; s < SLOTS; s++) begin
            ready_ff[s] <= 1'b0;
            count_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wctr_ff      <= wctr_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         tag0_ff      <= tag0_in;
         ready_ff     <= ready_in;
         count_ff     <= count_in;
      end
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      arg_ff      <= arg_in;
      w_ff        <= w_in;
      drain_ff    <= drain_in;
      k_ff        <= k_in;
      qmode_ff    <= qmode_in;
      res_st_ff   <= res_st_in;
      res_cnt_ff  <= res_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      stg_q_ff    <= stg_q_in;
   end

   // Staging words for the vector being streamed in
   always_ff @(posedge clock) begin
      if (stg_we) begin
         staging_ff[wctr_ff] <= req_lanes;
      end
   end

   // Vector store
   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_addr] <= staging_ff[w_ff];
      end
      vec_q_ff <= vec_mem[vec_addr];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (vld_we) begin
         valid_mem[vld_waddr] <= vld_wdata;
      end
      vld_q_ff <= valid_mem[vld_raddr];
   end

   // Word read from memory meets its tags; the valid bit marks a hit
   always_comb begin
      dot_tag     = tag0_ff;
      dot_tag.hit = vld_q_ff;
   end

   etk_dot u_dot (
      .clock  (clock),
      .reset  (reset),
      .tag_i  (dot_tag),
      .vec_i  (vec_q_ff),
      .stg_i  (stg_q_ff),
      .cand_o (cand)
   );

   etk_topk u_topk (
      .clock   (clock),
      .reset   (reset),
      .clear_i (topk_clear),
      .want_i  (want),
      .cand_i  (cand),
      .score_o (topk_score),
      .index_o (topk_index),
      .count_o (topk_n)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/core/etk_dot.sv]
module etk_dot import etk_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dot_tag_type          tag_i,
   input  logic [WORD_BITS-1:0] vec_i,
   input  logic [WORD_BITS-1:0] stg_i,
   output cand_type             cand_o
);

   dot_tag_type        tag1_ff, tag2_ff;
   logic [PROD_W-1:0]  prod_ff [LANES];
   logic [PROD_W-1:0]  prod_in [LANES];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SCORE_W-1:0] acc_ff, acc_in;
   cand_type           cand_ff, cand_in;

   // One multiplier per lane, then merge the lanes and accumulate the words
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         prod_in[l] = vec_i[l*BYTE_W +: BYTE_W] * stg_i[l*BYTE_W +: BYTE_W];
      end
      sum_in = '0;
      for (int l = 0; l < LANES; l++) begin
         sum_in = sum_in + SUM_W'(prod_ff[l]);
      end
      acc_in = acc_ff;
      if (tag2_ff.valid) begin
         acc_in = tag2_ff.first ? SCORE_W'(sum_ff) : acc_ff + SCORE_W'(sum_ff);
      end
      cand_in.valid = tag2_ff.valid & tag2_ff.last & tag2_ff.hit;
      cand_in.score = acc_in;
      cand_in.index = tag2_ff.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         cand_ff <= '0;
      end else begin
         tag1_ff <= tag_i;
         tag2_ff <= tag1_ff;
         cand_ff <= cand_in;
      end
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      acc_ff  <= acc_in;
   end

   assign cand_o = cand_ff;

endmodule

[rtl/core/etk_topk.sv]
module etk_topk import etk_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear_i,
   input  logic [KN_W-1:0]    want_i,
   input  cand_type           cand_i,
   output logic [SCORE_W-1:0] score_o [TOP_K],
   output logic [ENT_W-1:0]   index_o [TOP_K],
   output logic [KN_W-1:0]    count_o
);

   logic [SCORE_W-1:0] sc_ff [TOP_K];
   logic [SCORE_W-1:0] sc_in [TOP_K];
   logic [ENT_W-1:0]   ix_ff [TOP_K];
   logic [ENT_W-1:0]   ix_in [TOP_K];
   logic [KN_W-1:0]    n_ff, n_in;
   logic [KN_W-1:0]    pos;

   // Place the candidate behind every held entry with an equal or higher score
   always_comb begin
      pos = '0;
      for (int j = 0; j < TOP_K; j++) begin
         if (KN_W'(j) < n_ff && cand_i.score <= sc_ff[j]) begin
            pos = pos + 1'b1;
         end
      end
      sc_in = sc_ff;
      ix_in = ix_ff;
      n_in  = n_ff;
      if (clear_i) begin
         n_in = '0;
      end else if (cand_i.valid && pos < want_i) begin
         for (int j = 1; j < TOP_K; j++) begin
            if (KN_W'(j) > pos) begin
               sc_in[j] = sc_ff[j-1];
               ix_in[j] = ix_ff[j-1];
            end
         end
         for (int j = 0; j < TOP_K; j++) begin
            if (KN_W'(j) == pos) begin
               sc_in[j] = cand_i.score;
               ix_in[j] = cand_i.index;
            end
         end
         if (n_ff < want_i) begin
            n_in = n_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
      sc_ff <= sc_in;
      ix_ff <= ix_in;
   end

   assign score_o = sc_ff;
   assign index_o = ix_ff;
   assign count_o = n_ff;

endmodule

[rtl/core/etk_checker.sv]
`include "assert_macros.svh"

module etk_checker import etk_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             req_tlast,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   logic [ST_W-1:0]   chk_status;
   logic [RANK_W-1:0] chk_rank;
   logic [MC_W-1:0]   chk_mc;
   logic              chk_req_hold;

   // Pick the result fields apart
   assign chk_status   = rsp_tdata[ST_W-1:0];
   assign chk_rank     = rsp_tdata[ST_W+IDX_W+SCORE_O_W +: RANK_W];
   assign chk_mc       = rsp_tdata[ST_W+IDX_W+SCORE_O_W+RANK_W +: MC_W];
   assign chk_req_hold = req_tvalid & req_tready & req_tlast & (^req_tdata | ~^req_tdata);

   // Hold a stalled result
   `ETK_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // Error results stand alone
   `ETK_ASSERT_IMP(a_err_single, clock, reset, rsp_tvalid && chk_status != STS_OK, rsp_tlast && chk_mc == '0, "error result is not a single empty result")

   // Empty results are single and unranked
   `ETK_ASSERT_IMP(a_empty_single, clock, reset, rsp_tvalid && chk_mc == '0, rsp_tlast && chk_rank == '0, "empty result malformed")

   // Rank stays below the match count
   `ETK_ASSERT_IMP(a_rank_range, clock, reset, rsp_tvalid && chk_mc != '0 && chk_req_hold == chk_req_hold, {1'b0, chk_rank} < chk_mc, "rank beyond match count")

endmodule

bind embedding_topk_index_top etk_checker u_etk_checker (.*);
